// ===== rtl/ardt_pkg.sv =====
// Shared codes and beat types for the address range device table.
`timescale 1ns / 1ps
`default_nettype none

package ardt_pkg;

  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_IDENTICAL = 3'd2;
  localparam logic [2:0] ST_OVERLAP   = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;
  localparam logic [2:0] ST_REJECTED  = 3'd5;

  // Slot indexes are sized for the largest supported table.
  localparam int IDX_W = 8;
  localparam int CNT_W = 6;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Request token that walks the row of cells, one cell per cycle.
  typedef struct packed {
    logic             vld;
    logic [1:0]       op;
    logic [63:0]      addr_lo;
    logic [63:0]      addr_hi;
    logic [7:0]       dev;
    logic             hit;
    logic [7:0]       hit_dev;
    logic             same;
    logic             free_v;
    logic [IDX_W-1:0] free_idx;
    logic [CNT_W-1:0] cnt;
  } tok_t;

  // Entry write broadcast to every cell when an insert commits.
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    logic [63:0]      lo;
    logic [63:0]      hi;
    logic [7:0]       dev;
  } wr_t;

endpackage

`default_nettype wire

// ===== rtl/ardt_cell.sv =====
// One table entry together with its stage of the request token chain.
`timescale 1ns / 1ps
`default_nettype none

module ardt_cell #(
  parameter int CELL_IDX = 0
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  ardt_pkg::tok_t    tok_i,
  input  ardt_pkg::wr_t     wr_i,
  output ardt_pkg::tok_t    tok_o
);
  import ardt_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic        valid_r;
  logic        valid_nxt;
  logic [63:0] low_r;
  logic [63:0] high_r;
  logic [7:0]  dev_r;
  tok_t        tok_r;
  tok_t        tok_nxt;
  logic        contains;
  logic        dev_eq;
  logic        wr_here;

  // For a lookup both token bounds carry the address, so one compare pair
  // serves lookup and insert containment.
  assign contains = valid_r && (low_r <= tok_i.addr_lo) && (tok_i.addr_hi <= high_r);
  assign dev_eq   = (dev_r == tok_i.dev);
  assign wr_here  = wr_i.en && (wr_i.idx == MY_IDX);

  always_comb begin
    tok_nxt   = tok_i;
    valid_nxt = valid_r;
    if (tok_i.vld) begin
      if (tok_i.op == OP_REMOVE) begin
        if (valid_r && dev_eq) begin
          valid_nxt = 1'b0;
          if (tok_i.cnt != CNT_MAX) begin
            tok_nxt.cnt = tok_i.cnt + CNT_W'(1);
          end
        end
      end else begin
        if (!tok_i.hit && contains) begin
          tok_nxt.hit     = 1'b1;
          tok_nxt.hit_dev = dev_r;
          tok_nxt.same    = dev_eq && (low_r == tok_i.addr_lo) &&
                            (high_r == tok_i.addr_hi);
        end
        if (tok_i.op == OP_INSERT && !valid_r && !tok_i.free_v) begin
          tok_nxt.free_v   = 1'b1;
          tok_nxt.free_idx = MY_IDX;
        end
      end
    end
    if (wr_here) begin
      valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      tok_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      tok_r   <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_here) begin
      low_r  <= wr_i.lo;
      high_r <= wr_i.hi;
      dev_r  <= wr_i.dev;
    end
  end

  assign tok_o = tok_r;

endmodule

`default_nettype wire

// ===== rtl/address_range_device_table.sv =====
// A table operation passes one cell per cycle; its result then goes through the
// pending register to the output registers behind out_valid, while a rejected beat
// goes straight to the pending register. One item is in the table at a time: the next
// beat is taken once the pending result has moved out, later while a stalled result
// still fills the output.
// Reset clears every entry valid bit and the enable at once; there is no
// clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module address_range_device_table #(
  parameter int TABLE_ENTRIES = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_checking_enabled,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_opcode,
  input  wire logic [63:0] in_address,
  input  wire logic [63:0] in_address_high,
  input  wire logic [7:0]  in_device_tag,
  input  wire logic [1:0]  in_resource_kind,
  input  wire logic        in_device_eligible,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_status,
  output logic [7:0]       out_found_device,
  output logic [5:0]       out_removed_count
);
  import ardt_pkg::*;

  logic       enable_r;
  logic       run_r;
  logic       run_nxt;
  logic       pend_r;
  logic       pend_nxt;
  logic [2:0] pend_status_r;
  logic [2:0] pend_status_nxt;
  logic [7:0] pend_dev_r;
  logic [7:0] pend_dev_nxt;
  logic [5:0] pend_cnt_r;
  logic [5:0] pend_cnt_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic [2:0] out_status_r;
  logic [7:0] out_dev_r;
  logic [5:0] out_cnt_r;
  logic       accept;
  logic       reject;
  logic       bad_bounds;
  logic       move_out;
  tok_t       tok_w [TABLE_ENTRIES+1];
  tok_t       tail;
  wr_t        wr;

  assign cfg_ready = rst_n;
  assign in_stall  = run_r | pend_r | !rst_n;
  assign accept    = in_valid && !in_stall;

  assign bad_bounds = (in_address == '0) || (in_address == '1) ||
                      (in_address_high == '0) || (in_address_high == '1);
  assign reject = !enable_r || (in_opcode != OP_LOOKUP && in_opcode != OP_INSERT &&
                  in_opcode != OP_REMOVE) ||
                  (in_opcode == OP_INSERT &&
                   (!in_device_eligible || in_resource_kind == 2'd0 || bad_bounds));

  always_comb begin
    tok_w[0]          = '0;
    tok_w[0].vld      = accept && !reject;
    tok_w[0].op       = in_opcode;
    tok_w[0].addr_lo  = in_address;
    tok_w[0].addr_hi  = (in_opcode == OP_LOOKUP) ? in_address : in_address_high;
    tok_w[0].dev      = in_device_tag;
  end

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    ardt_cell #(.CELL_IDX(i)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .tok_i (tok_w[i]),
      .wr_i  (wr),
      .tok_o (tok_w[i+1])
    );
  end

  assign tail = tok_w[TABLE_ENTRIES];

  // An insert commits into the lowest free slot once the whole row has
  // confirmed that no entry contains the new range.
  always_comb begin
    wr.en  = tail.vld && tail.op == OP_INSERT && !tail.hit && tail.free_v;
    wr.idx = tail.free_idx;
    wr.lo  = tail.addr_lo;
    wr.hi  = tail.addr_hi;
    wr.dev = tail.dev;
  end

  assign move_out = pend_r && (!out_valid_r || !out_stall);

  always_comb begin
    run_nxt         = run_r;
    pend_nxt        = pend_r;
    pend_status_nxt = pend_status_r;
    pend_dev_nxt    = pend_dev_r;
    pend_cnt_nxt    = pend_cnt_r;
    out_valid_nxt   = out_valid_r;
    if (move_out) begin
      pend_nxt      = 1'b0;
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (accept) begin
      if (reject) begin
        pend_nxt        = 1'b1;
        pend_status_nxt = ST_REJECTED;
        pend_dev_nxt    = '0;
        pend_cnt_nxt    = '0;
      end else begin
        run_nxt = 1'b1;
      end
    end
    if (tail.vld) begin
      run_nxt      = 1'b0;
      pend_nxt     = 1'b1;
      pend_dev_nxt = '0;
      pend_cnt_nxt = '0;
      case (tail.op)
        OP_LOOKUP: begin
          pend_status_nxt = tail.hit ? ST_OK : ST_NOT_FOUND;
          pend_dev_nxt    = tail.hit ? tail.hit_dev : 8'd0;
        end
        OP_INSERT: begin
          if (tail.hit) begin
            pend_status_nxt = tail.same ? ST_IDENTICAL : ST_OVERLAP;
            pend_dev_nxt    = tail.hit_dev;
          end else begin
            pend_status_nxt = tail.free_v ? ST_OK : ST_FULL;
          end
        end
        default: begin
          pend_status_nxt = ST_OK;
          pend_cnt_nxt    = tail.cnt;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r    <= 1'b0;
      run_r       <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        enable_r <= cfg_checking_enabled;
      end
      run_r       <= run_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_status_r <= pend_status_nxt;
    pend_dev_r    <= pend_dev_nxt;
    pend_cnt_r    <= pend_cnt_nxt;
    if (move_out) begin
      out_status_r <= pend_status_r;
      out_dev_r    <= pend_dev_r;
      out_cnt_r    <= pend_cnt_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_found_device  = out_dev_r;
  assign out_removed_count = out_cnt_r;

endmodule

`default_nettype wire

// ===== rtl/ardt_chk.sv =====
// Port-level checks for the address range device table, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module ardt_chk (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [2:0] out_status,
  input wire logic [7:0] out_found_device,
  input wire logic [5:0] out_removed_count
);
  import ardt_pkg::*;

  // Only one item is in flight, so an accepted beat closes the input.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted while an item is in flight");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK || out_status == ST_NOT_FOUND ||
                   out_status == ST_IDENTICAL || out_status == ST_OVERLAP ||
                   out_status == ST_FULL || out_status == ST_REJECTED))
    else $error("result status outside the defined codes");

  a_empty_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_NOT_FOUND || out_status == ST_FULL ||
                  out_status == ST_REJECTED) |->
    out_found_device == 8'd0 && out_removed_count == 6'd0)
    else $error("failed result carries a device or count");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) &&
    $stable(out_found_device) && $stable(out_removed_count))
    else $error("stalled result beat changed");

endmodule

bind address_range_device_table ardt_chk u_ardt_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_status        (out_status),
  .out_found_device  (out_found_device),
  .out_removed_count (out_removed_count)
);

`default_nettype wire

// ===== tb/ardt_table_check.sv =====
// Checker for the address range device table: predicts every answer and compares it.
`timescale 1ns / 1ps

module ardt_table_check #(
  parameter int TABLE_ENTRIES = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic        cfg_checking_enabled,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic [1:0]  in_opcode,
  input  wire logic [63:0] in_address,
  input  wire logic [63:0] in_address_high,
  input  wire logic [7:0]  in_device_tag,
  input  wire logic [1:0]  in_resource_kind,
  input  wire logic        in_device_eligible,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic [2:0]  out_status,
  input  wire logic [7:0]  out_found_device,
  input  wire logic [5:0]  out_removed_count,
  output int               mismatches,
  output int               outstanding
);
  import ardt_pkg::*;

  typedef struct packed {
    logic [2:0]       status;
    logic [7:0]       dev;
    logic [CNT_W-1:0] count;
  } answer_t;

  logic        enabled;
  logic        slot_used [TABLE_ENTRIES];
  logic [63:0] slot_lo   [TABLE_ENTRIES];
  logic [63:0] slot_hi   [TABLE_ENTRIES];
  logic [7:0]  slot_dev  [TABLE_ENTRIES];
  answer_t     pending_answers [$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  // Works out the answer to one request and applies it to the shadow table.
  function automatic answer_t table_answer(input logic [1:0] op, input logic [63:0] lo,
                                           input logic [63:0] hi, input logic [7:0] dev,
                                           input logic [1:0] kind, input logic eligible);
    answer_t a;
    int      free_slot;
    int      i;
    a         = '0;
    a.status  = ST_REJECTED;
    free_slot = -1;
    if (!enabled) return a;
    case (op)
      OP_LOOKUP: begin
        a.status = ST_NOT_FOUND;
        for (i = 0; i < TABLE_ENTRIES; i++) begin
          if (slot_used[i] && slot_lo[i] <= lo && lo <= slot_hi[i]) begin
            a.status = ST_OK;
            a.dev    = slot_dev[i];
            return a;
          end
        end
      end
      OP_INSERT: begin
        if (!eligible || ~|kind || lo == '0 || lo == '1 || hi == '0 || hi == '1) return a;
        for (i = 0; i < TABLE_ENTRIES; i++) begin
          if (slot_used[i]) begin
            if (slot_lo[i] <= lo && hi <= slot_hi[i]) begin
              a.status = (slot_dev[i] == dev && slot_lo[i] == lo && slot_hi[i] == hi) ?
                         ST_IDENTICAL : ST_OVERLAP;
              a.dev    = slot_dev[i];
              return a;
            end
          end else if (free_slot < 0) begin
            free_slot = i;
          end
        end
        if (free_slot < 0) begin
          a.status = ST_FULL;
          return a;
        end
        slot_used[free_slot] = 1'b1;
        slot_lo[free_slot]   = lo;
        slot_hi[free_slot]   = hi;
        slot_dev[free_slot]  = dev;
        a.status             = ST_OK;
      end
      OP_REMOVE: begin
        a.status = ST_OK;
        for (i = 0; i < TABLE_ENTRIES; i++) begin
          if (slot_used[i] && slot_dev[i] == dev) begin
            slot_used[i] = 1'b0;
            if (a.count != CNT_MAX) a.count = a.count + 1'b1;
          end
        end
      end
      default: ;
    endcase
    return a;
  endfunction

  task automatic report_field(input string what, input int unsigned want,
                              input int unsigned got);
    mismatches++;
    $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
  endtask

  always @(posedge clk) begin : watch
    answer_t want;
    answer_t got;
    int      i;
    if (!rst_n) begin
      enabled = 1'b0;
      for (i = 0; i < TABLE_ENTRIES; i++) slot_used[i] = 1'b0;
      pending_answers.delete();
    end else begin
      // A result beat can never be the answer to a request taken at the same edge.
      if (out_valid && !out_stall) begin
        got = {out_status, out_found_device, out_removed_count};
        if (pending_answers.size() == 0) begin
          mismatches++;
          $display("%0t ns: unexpected result beat, expected none, actual %0d/%0d/%0d",
                   $time, got.status, got.dev, got.count);
        end else begin
          want = pending_answers.pop_front();
          if (got.status !== want.status) report_field("status", want.status, got.status);
          if (got.dev !== want.dev) report_field("found_device", want.dev, got.dev);
          if (got.count !== want.count) report_field("removed_count", want.count, got.count);
        end
      end
      // A request taken at the same edge as a register write still sees the old enable.
      if (in_valid && !in_stall)
        pending_answers.push_back(table_answer(in_opcode, in_address, in_address_high,
                                               in_device_tag, in_resource_kind,
                                               in_device_eligible));
      if (cfg_valid && cfg_ready) enabled = cfg_checking_enabled;
    end
    outstanding <= pending_answers.size();
  end

endmodule

// ===== tb/address_range_device_table_tb.sv =====
// Top of the address range device table testbench: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module address_range_device_table_tb;
  import ardt_pkg::*;

  localparam int TABLE_ENTRIES = 32;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int HOLD_CYCLES   = 300;
  localparam int SPAN_MEMORY   = 16;

  localparam logic [1:0]  OP_UNUSED = 2'd3;
  localparam logic [1:0]  KIND_NONE = 2'b00;
  localparam logic [1:0]  KIND_IO   = 2'b01;
  localparam logic [1:0]  KIND_MEM  = 2'b10;
  localparam logic [63:0] ALL_ONES  = '1;

  typedef struct packed {
    logic [63:0] lo;
    logic [63:0] hi;
    logic [7:0]  dev;
  } span_t;

  logic        clk                  = 1'b0;
  logic        rst_n                = 1'b0;
  logic        cfg_valid            = 1'b0;
  logic        cfg_checking_enabled = 1'b0;
  logic        in_valid             = 1'b0;
  logic [1:0]  in_opcode            = OP_LOOKUP;
  logic [63:0] in_address           = '0;
  logic [63:0] in_address_high      = '0;
  logic [7:0]  in_device_tag        = '0;
  logic [1:0]  in_resource_kind     = KIND_NONE;
  logic        in_device_eligible   = 1'b0;
  logic        out_stall            = 1'b0;
  logic        cfg_ready;
  logic        in_stall;
  logic        out_valid;
  logic [2:0]  out_status;
  logic [7:0]  out_found_device;
  logic [5:0]  out_removed_count;

  int    mismatches;
  int    outstanding;
  int    idle_pct      = 30;
  int    stall_pct     = 10;
  int    hold_requests = 0;
  int    hold_served   = 0;
  int    hold_left     = 0;
  int    cycles        = 0;
  span_t recent_spans [$];

  address_range_device_table #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_checking_enabled(cfg_checking_enabled),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_opcode           (in_opcode),
    .in_address          (in_address),
    .in_address_high     (in_address_high),
    .in_device_tag       (in_device_tag),
    .in_resource_kind    (in_resource_kind),
    .in_device_eligible  (in_device_eligible),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_found_device    (out_found_device),
    .out_removed_count   (out_removed_count)
  );

  ardt_table_check #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) table_check (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_checking_enabled(cfg_checking_enabled),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_opcode           (in_opcode),
    .in_address          (in_address),
    .in_address_high     (in_address_high),
    .in_device_tag       (in_device_tag),
    .in_resource_kind    (in_resource_kind),
    .in_device_eligible  (in_device_eligible),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_found_device    (out_found_device),
    .out_removed_count   (out_removed_count),
    .mismatches          (mismatches),
    .outstanding         (outstanding)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Result side: random stalls, plus a long hold-off whenever one is requested.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_requests) begin
      out_stall   <= 1'b1;
      hold_left   <= HOLD_CYCLES;
      hold_served <= hold_served + 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] grid_address();
    logic [63:0] g;
    g = 64'($urandom_range(1, 64));
    return g << 4;
  endfunction

  function automatic logic [63:0] boundary_value();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return 64'd1;
      2:       return ALL_ONES - 64'd1;
      default: return ALL_ONES;
    endcase
  endfunction

  task automatic send_item(input logic [1:0] op, input logic [63:0] lo, input logic [63:0] hi,
                           input logic [7:0] dev, input logic [1:0] kind,
                           input logic eligible);
    int gap;
    if ($urandom_range(99) < idle_pct) begin
      gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_opcode          <= op;
    in_address         <= lo;
    in_address_high    <= hi;
    in_device_tag      <= dev;
    in_resource_kind   <= kind;
    in_device_eligible <= eligible;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (op == OP_INSERT) begin
      recent_spans.push_back({lo, hi, dev});
      if (recent_spans.size() > SPAN_MEMORY) void'(recent_spans.pop_front());
    end
  endtask

  // Stops offering beats and waits until every answer has come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_enable(input logic value);
    drain();
    cfg_valid            <= 1'b1;
    cfg_checking_enabled <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly small ranges on a coarse grid so that containment and a full table
  // come up often; wide random values keep every address bit moving.
  task automatic random_item();
    logic [1:0]  op;
    logic [1:0]  kind;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] width;
    logic [7:0]  dev;
    logic        eligible;
    span_t       s;
    int          r;
    r = $urandom_range(99);
    if (r < 40) op = OP_LOOKUP;
    else if (r < 85) op = OP_INSERT;
    else if (r < 97) op = OP_REMOVE;
    else op = OP_UNUSED;
    if ($urandom_range(99) < 80) dev = 8'($urandom_range(0, 7));
    else dev = 8'($urandom_range(0, 255));
    if ($urandom_range(99) < 5) kind = KIND_NONE;
    else kind = 2'($urandom_range(1, 3));
    eligible = ($urandom_range(99) >= 5);
    lo       = rand64();
    hi       = rand64();
    s        = '0;
    if (recent_spans.size() > 0) s = recent_spans[$urandom_range(0, recent_spans.size() - 1)];
    r = $urandom_range(99);
    if (op == OP_LOOKUP) begin
      if (r < 50 && recent_spans.size() > 0) lo = s.lo + 64'($urandom_range(0, 31));
      else if (r < 75) lo = grid_address() + 64'($urandom_range(0, 15));
      else if (r >= 90) lo = boundary_value();
    end else if (op == OP_INSERT) begin
      if (r < 55) begin
        width = 64'($urandom_range(0, 8));
        lo    = grid_address();
        hi    = lo + (width << 4) + 64'd15;
      end else if (r < 75 && recent_spans.size() > 0) begin
        if ($urandom_range(1)) begin
          lo  = s.lo;
          hi  = s.hi;
          dev = s.dev;
        end else begin
          lo = s.lo + 64'd1;
          hi = s.hi - 64'd1;
        end
      end else if (r >= 90) begin
        lo = boundary_value();
        hi = boundary_value();
      end
    end
    send_item(op, lo, hi, dev, kind, eligible);
  endtask

  initial begin
    int n;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Checking is off out of reset, so both of these are refused.
    send_item(OP_LOOKUP, 64'h1000, 64'h0, 8'h01, KIND_IO, 1'b1);
    send_item(OP_INSERT, 64'h1000, 64'h1FFF, 8'h01, KIND_IO, 1'b1);
    write_enable(1'b1);

    send_item(OP_LOOKUP, 64'h0, ALL_ONES, 8'h00, KIND_IO, 1'b1);
    send_item(OP_INSERT, 64'h1000, 64'h1FFF, 8'h01, KIND_IO, 1'b1);
    send_item(OP_INSERT, 64'h1000, 64'h1FFF, 8'h01, KIND_IO, 1'b1);
    send_item(OP_INSERT, 64'h1100, 64'h1200, 8'h02, KIND_MEM, 1'b1);
    send_item(OP_INSERT, 64'h1, ALL_ONES - 64'd1, 8'hFF, KIND_IO | KIND_MEM, 1'b1);
    // The first entry shadows the wide one wherever both hold the address.
    send_item(OP_LOOKUP, 64'h1000, 64'h0, 8'h00, KIND_IO, 1'b1);
    send_item(OP_LOOKUP, 64'h1FFF, 64'h0, 8'h00, KIND_IO, 1'b1);
    send_item(OP_LOOKUP, 64'h2000, 64'h0, 8'h00, KIND_IO, 1'b1);
    send_item(OP_LOOKUP, 64'h0, 64'h0, 8'h00, KIND_IO, 1'b1);
    send_item(OP_LOOKUP, ALL_ONES, ALL_ONES, 8'hFF, KIND_IO | KIND_MEM, 1'b1);
    send_item(OP_REMOVE, 64'h0, 64'h0, 8'hFF, KIND_IO, 1'b1);
    send_item(OP_INSERT, 64'h3000, 64'h3FFF, 8'h04, KIND_IO, 1'b0);
    send_item(OP_INSERT, 64'h3000, 64'h3FFF, 8'h04, KIND_NONE, 1'b1);
    send_item(OP_INSERT, 64'h0, 64'h3FFF, 8'h04, KIND_IO, 1'b1);
    send_item(OP_INSERT, ALL_ONES, 64'h3FFF, 8'h04, KIND_MEM, 1'b1);
    send_item(OP_INSERT, 64'h3000, 64'h0, 8'h04, KIND_IO, 1'b1);
    send_item(OP_INSERT, 64'h3000, ALL_ONES, 8'h04, KIND_MEM, 1'b1);
    send_item(OP_INSERT, 64'h9000, 64'h8000, 8'h03, KIND_MEM, 1'b1);
    send_item(OP_LOOKUP, 64'h8800, 64'h0, 8'h00, KIND_IO, 1'b1);
    send_item(OP_UNUSED, 64'h1000, 64'h1FFF, 8'h01, KIND_IO, 1'b1);
    send_item(OP_REMOVE, 64'h0, 64'h0, 8'h77, KIND_IO, 1'b1);

    for (n = 0; n < 1000; n++) begin
      if (n >= 300 && n < 500) begin
        idle_pct  = 0;
        stall_pct = 0;
      end else begin
        idle_pct  = 30;
        stall_pct = 10;
      end
      // The sender keeps offering beats through the hold-off, so the block backs up.
      if (n == 700) hold_requests++;
      if (n == 850) drain();
      random_item();
    end

    write_enable(1'b0);
    for (n = 0; n < 100; n++) random_item();

    write_enable(1'b1);
    for (n = 0; n < 850; n++) random_item();

    drain();
    repeat (TABLE_ENTRIES + 5) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== address_range_device_table.f =====
rtl/ardt_pkg.sv
rtl/ardt_cell.sv
rtl/address_range_device_table.sv
rtl/ardt_chk.sv
tb/ardt_table_check.sv
tb/address_range_device_table_tb.sv
